>>> src/triangle_box_overlap_test_macros.svh
// assertion macros shared by the triangle/box overlap test rtl
`ifndef TRIANGLE_BOX_OVERLAP_TEST_MACROS_SVH
`define TRIANGLE_BOX_OVERLAP_TEST_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TBOT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbot same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define TBOT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbot next-cycle check failed");

`endif

>>> src/tbot_pkg.sv
// shared types, codes and cross-axis selection tables for the overlap test
`default_nettype none

package tbot_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int NUM_CROSS = 9;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_CENTRE_X = 3'd0,
        CFG_CENTRE_Y = 3'd1,
        CFG_CENTRE_Z = 3'd2,
        CFG_HALF_X   = 3'd3,
        CFG_HALF_Y   = 3'd4,
        CFG_HALF_Z   = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        REJECT_NONE  = 2'd0,
        REJECT_BOX   = 2'd1,
        REJECT_PLANE = 2'd2,
        REJECT_CROSS = 2'd3
    } reject_t;

    // edge, box axis and the two vertices projected for each cross axis
    localparam logic [1:0] EDGE_SEL [NUM_CROSS] =
        '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] AXIS_SEL [NUM_CROSS] =
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] VTX_P [NUM_CROSS] =
        '{2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1};
    localparam logic [1:0] VTX_Q [NUM_CROSS] =
        '{2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2};

    // first and second component of the plane orthogonal to a box axis
    function automatic logic [1:0] axis_u(input logic [1:0] ax);
        return (ax == 2'd0) ? 2'd1 : 2'd0;
    endfunction

    function automatic logic [1:0] axis_w(input logic [1:0] ax);
        return (ax == 2'd2) ? 2'd1 : 2'd2;
    endfunction

endpackage

`default_nettype wire

>>> src/tbot_if.sv
// valid/ready channels: triangle word in, overlap result word out
`default_nettype none

interface tbot_triangle_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex0_x;
    logic signed [COORD_WIDTH-1:0] vertex0_y;
    logic signed [COORD_WIDTH-1:0] vertex0_z;
    logic signed [COORD_WIDTH-1:0] vertex1_x;
    logic signed [COORD_WIDTH-1:0] vertex1_y;
    logic signed [COORD_WIDTH-1:0] vertex1_z;
    logic signed [COORD_WIDTH-1:0] vertex2_x;
    logic signed [COORD_WIDTH-1:0] vertex2_y;
    logic signed [COORD_WIDTH-1:0] vertex2_z;
    logic signed [COORD_WIDTH-1:0] normal_x;
    logic signed [COORD_WIDTH-1:0] normal_y;
    logic signed [COORD_WIDTH-1:0] normal_z;

    modport source (
        output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
               vertex2_x, vertex2_y, vertex2_z, normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
               vertex2_x, vertex2_y, vertex2_z, normal_x, normal_y, normal_z,
        output ready
    );
endinterface

interface tbot_result_if ();
    logic       valid;
    logic       ready;
    logic       overlap;
    logic [1:0] reject_stage;

    modport source (output valid, overlap, reject_stage, input ready);
    modport sink (input valid, overlap, reject_stage, output ready);
endinterface

`default_nettype wire

>>> src/tbot_cross_axis.sv
// one edge-cross-axis separation test: registered products, then sum and compare
`default_nettype none

module tbot_cross_axis #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            load,
    input  logic signed [COORD_WIDTH+1:0]   edge_a,
    input  logic signed [COORD_WIDTH+1:0]   edge_b,
    input  logic signed [COORD_WIDTH:0]     p_u,
    input  logic signed [COORD_WIDTH:0]     p_w,
    input  logic signed [COORD_WIDTH:0]     q_u,
    input  logic signed [COORD_WIDTH:0]     q_w,
    input  logic        [COORD_WIDTH-2:0]   half_u,
    input  logic        [COORD_WIDTH-2:0]   half_w,
    output logic                            separated
);

    localparam int EW  = COORD_WIDTH + 2;
    localparam int MW  = COORD_WIDTH + 1;
    localparam int PRW = 2 * COORD_WIDTH + 3;
    localparam int RW  = 2 * COORD_WIDTH;
    localparam int PW  = 2 * COORD_WIDTH + 5;

    logic signed [EW-1:0]  a_signed;
    logic signed [EW-1:0]  b_signed;
    logic        [MW-1:0]  a_abs;
    logic        [MW-1:0]  b_abs;
    logic signed [PRW-1:0] apu_next, bpw_next, aqu_next, bqw_next;
    logic signed [PRW-1:0] apu_reg, bpw_reg, aqu_reg, bqw_reg;
    logic        [RW-1:0]  rad_a_next, rad_b_next;
    logic        [RW-1:0]  rad_a_reg, rad_b_reg;
    logic signed [PW-1:0]  pp, qq, rad, rad_neg;
    logic        [PW-1:0]  rad_sum;

    // edge components never reach the most negative code, so negation is safe
    assign a_signed = edge_a[EW-1] ? -edge_a : edge_a;
    assign b_signed = edge_b[EW-1] ? -edge_b : edge_b;
    assign a_abs    = a_signed[MW-1:0];
    assign b_abs    = b_signed[MW-1:0];

    always_comb
    begin
        apu_next   = PRW'(edge_a) * PRW'(p_u);
        bpw_next   = PRW'(edge_b) * PRW'(p_w);
        aqu_next   = PRW'(edge_a) * PRW'(q_u);
        bqw_next   = PRW'(edge_b) * PRW'(q_w);
        rad_a_next = RW'(a_abs) * RW'(half_u);
        rad_b_next = RW'(b_abs) * RW'(half_w);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            apu_reg   <= apu_next;
            bpw_reg   <= bpw_next;
            aqu_reg   <= aqu_next;
            bqw_reg   <= bqw_next;
            rad_a_reg <= rad_a_next;
            rad_b_reg <= rad_b_next;
        end
    end

    // both projections strictly beyond the same side of [-rad, rad]
    always_comb
    begin
        pp        = PW'(apu_reg) - PW'(bpw_reg);
        qq        = PW'(aqu_reg) - PW'(bqw_reg);
        rad_sum   = PW'(rad_a_reg) + PW'(rad_b_reg);
        rad       = $signed(rad_sum);
        rad_neg   = -rad;
        separated = ((pp > rad) && (qq > rad)) || ((pp < rad_neg) && (qq < rad_neg));
    end

endmodule

`default_nettype wire

>>> src/triangle_box_overlap_test.sv
// top level of the triangle versus axis-aligned box overlap test
`default_nettype none
`include "triangle_box_overlap_test_macros.svh"

// Separating-axis overlap test of one triangle against a configured box. A word on
// the triangle channel carries three vertices and the plane normal, signed Q16.16
// at COORD_WIDTH bits; the result word gives overlap and the first stage that
// found a separating axis (box axes, triangle plane, then the NUM_CROSS edge cross
// axes). Touching counts as overlap. All products and sums are exact, no rounding.
// The block accepts one triangle every clock while it is not stalled. There are
// three register stages: vertices relative to the centre, the products (six for
// the plane, six in each cross-axis unit), and the sums with their compares
// feeding the result register. An accepted triangle moves through stage 1 and
// stage 2 into the result register, which holds its word. Back-pressure on the
// result channel stalls the stages in place; empty stages keep filling, so ready
// stays high until every stage holds a word. There is no clearing pass after
// reset. Box registers are written through write_enable/write_index/write_data;
// writes to indexes beyond the half sizes are ignored. Change them only while no
// triangle is in flight. The triangle interface must be built with the same
// COORD_WIDTH.

module triangle_box_overlap_test #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  write_enable,
    input  logic [tbot_pkg::CFG_INDEX_WIDTH-1:0]  write_index,
    input  logic [COORD_WIDTH-1:0]                write_data,
    tbot_triangle_if.sink                         triangle,
    tbot_result_if.source                         result
);

    import tbot_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int VW  = W + 1;          // vertex relative to centre
    localparam int EW  = W + 2;          // edge vector component
    localparam int HW  = W - 1;          // half size
    localparam int PRW = 2 * W + 3;      // registered product
    localparam int PW  = 2 * W + 5;      // sum of products

    // box registers
    logic signed [W-1:0]   centre_reg  [3];
    logic signed [W-1:0]   centre_next [3];
    logic        [HW-1:0]  half_reg    [3];
    logic        [HW-1:0]  half_next   [3];

    // pipeline control
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s2_valid_reg, s2_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free, s2_free, s1_free;
    logic                  s1_load, s2_load, out_load;

    // stage 1: relative vertices and normal
    logic signed [W-1:0]   vin         [3][3];
    logic signed [W-1:0]   nin         [3];
    logic signed [VW-1:0]  v_next      [3][3];
    logic signed [VW-1:0]  v_reg       [3][3];
    logic signed [W-1:0]   n_reg       [3];

    // stage 2: box-axis flag and plane products
    logic signed [EW-1:0]  e           [3][3];
    logic signed [VW-1:0]  half_s      [3];
    logic signed [VW-1:0]  half_neg    [3];
    logic signed [EW-1:0]  h_sel       [3];
    logic signed [EW-1:0]  t_min       [3];
    logic signed [EW-1:0]  t_max       [3];
    logic signed [PRW-1:0] pmin_next   [3];
    logic signed [PRW-1:0] pmax_next   [3];
    logic signed [PRW-1:0] pmin_reg    [3];
    logic signed [PRW-1:0] pmax_reg    [3];
    logic [2:0]            axis_sep;
    logic                  box_sep_next, box_sep_reg;

    // stage 3: sums, compares, result word
    logic signed [PW-1:0]  dmin, dmax;
    logic                  plane_sep;
    logic [NUM_CROSS-1:0]  cross_sep;
    reject_t               stage_next, stage_reg;
    logic                  overlap_next, overlap_reg;

    // ---------------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------------
    always_comb
    begin
        centre_next = centre_reg;
        half_next   = half_reg;
        if (write_enable)
        begin
            case (write_index)
                CFG_CENTRE_X: centre_next[0] = write_data;
                CFG_CENTRE_Y: centre_next[1] = write_data;
                CFG_CENTRE_Z: centre_next[2] = write_data;
                CFG_HALF_X:   half_next[0]   = write_data[HW-1:0];
                CFG_HALF_Y:   half_next[1]   = write_data[HW-1:0];
                CFG_HALF_Z:   half_next[2]   = write_data[HW-1:0];
                default:      ;  // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_reg <= '{default: '0};
            half_reg   <= '{default: '0};
        end
        else
        begin
            centre_reg <= centre_next;
            half_reg   <= half_next;
        end
    end

    // ---------------------------------------------------------------------
    // handshake: each stage moves when the one after it is empty or moving
    // ---------------------------------------------------------------------
    always_comb
    begin
        out_free       = !out_valid_reg || result.ready;
        s2_free        = !s2_valid_reg || out_free;
        s1_free        = !s1_valid_reg || s2_free;
        s1_load        = triangle.valid && s1_free;
        s2_load        = s1_valid_reg && s2_free;
        out_load       = s2_valid_reg && out_free;
        s1_valid_next  = s1_free  ? triangle.valid : s1_valid_reg;
        s2_valid_next  = s2_free  ? s1_valid_reg   : s2_valid_reg;
        out_valid_next = out_free ? s2_valid_reg   : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign triangle.ready      = s1_free;
    assign result.valid        = out_valid_reg;
    assign result.overlap      = overlap_reg;
    assign result.reject_stage = stage_reg;

    // ---------------------------------------------------------------------
    // stage 1: move the vertices into box-centred coordinates
    // ---------------------------------------------------------------------
    assign vin[0][0] = triangle.vertex0_x;
    assign vin[0][1] = triangle.vertex0_y;
    assign vin[0][2] = triangle.vertex0_z;
    assign vin[1][0] = triangle.vertex1_x;
    assign vin[1][1] = triangle.vertex1_y;
    assign vin[1][2] = triangle.vertex1_z;
    assign vin[2][0] = triangle.vertex2_x;
    assign vin[2][1] = triangle.vertex2_y;
    assign vin[2][2] = triangle.vertex2_z;
    assign nin[0]    = triangle.normal_x;
    assign nin[1]    = triangle.normal_y;
    assign nin[2]    = triangle.normal_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                v_next[i][k] = VW'(vin[i][k]) - VW'(centre_reg[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            v_reg <= v_next;
            n_reg <= nin;
        end
    end

    // ---------------------------------------------------------------------
    // stage 2: edges, box axes, plane products
    // ---------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e[i][k] = EW'(v_reg[(i == 2) ? 0 : i + 1][k]) - EW'(v_reg[i][k]);
            end
        end

        for (int k = 0; k < 3; k++)
        begin
            half_s[k]   = $signed(VW'(half_reg[k]));
            half_neg[k] = -half_s[k];
            // all three vertices past the same face means min/max is outside
            axis_sep[k] = ((v_reg[0][k] > half_s[k]) && (v_reg[1][k] > half_s[k]) &&
                           (v_reg[2][k] > half_s[k])) ||
                          ((v_reg[0][k] < half_neg[k]) && (v_reg[1][k] < half_neg[k]) &&
                           (v_reg[2][k] < half_neg[k]));

            // box corner picked by the sign of the normal
            h_sel[k]     = (n_reg[k] > 0) ? EW'(half_s[k]) : -EW'(half_s[k]);
            t_min[k]     = -h_sel[k] - EW'(v_reg[0][k]);
            t_max[k]     = h_sel[k] - EW'(v_reg[0][k]);
            pmin_next[k] = PRW'(n_reg[k]) * PRW'(t_min[k]);
            pmax_next[k] = PRW'(n_reg[k]) * PRW'(t_max[k]);
        end
        box_sep_next = |axis_sep;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            box_sep_reg <= box_sep_next;
            pmin_reg    <= pmin_next;
            pmax_reg    <= pmax_next;
        end
    end

    // NUM_CROSS edge cross axes, each with its own product registers
    for (genvar j = 0; j < NUM_CROSS; j++)
    begin : g_cross
        localparam logic [1:0] AX = AXIS_SEL[j];
        localparam logic [1:0] AU = axis_u(AX);
        localparam logic [1:0] AW = axis_w(AX);

        tbot_cross_axis #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cross (
            .clk       (clk),
            .load      (s2_load),
            .edge_a    (e[EDGE_SEL[j]][AW]),
            .edge_b    (e[EDGE_SEL[j]][AU]),
            .p_u       (v_reg[VTX_P[j]][AU]),
            .p_w       (v_reg[VTX_P[j]][AW]),
            .q_u       (v_reg[VTX_Q[j]][AU]),
            .q_w       (v_reg[VTX_Q[j]][AW]),
            .half_u    (half_reg[AU]),
            .half_w    (half_reg[AW]),
            .separated (cross_sep[j])
        );
    end

    // ---------------------------------------------------------------------
    // stage 3: plane sums, priority of reject stages, result register
    // ---------------------------------------------------------------------
    always_comb
    begin
        dmin      = PW'(pmin_reg[0]) + PW'(pmin_reg[1]) + PW'(pmin_reg[2]);
        dmax      = PW'(pmax_reg[0]) + PW'(pmax_reg[1]) + PW'(pmax_reg[2]);
        plane_sep = (dmin > 0) || (dmax < 0);

        // earliest failing test wins
        if (box_sep_reg)
            stage_next = REJECT_BOX;
        else if (plane_sep)
            stage_next = REJECT_PLANE;
        else if (|cross_sep)
            stage_next = REJECT_CROSS;
        else
            stage_next = REJECT_NONE;
        overlap_next = (stage_next == REJECT_NONE);
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            stage_reg   <= stage_next;
            overlap_reg <= overlap_next;
        end
    end

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------
    // overlap flag and reject code agree on every result word
    `TBOT_ASSERT_SAME(a_overlap_code, out_valid_reg, overlap_reg == (stage_reg == REJECT_NONE))
    // an accepted triangle always lands in stage 1
    `TBOT_ASSERT_NEXT(a_accept_fills_s1, triangle.valid && triangle.ready, s1_valid_reg)
    // a rise of result.valid only ever comes from a full stage 2
    `TBOT_ASSERT_SAME(a_result_from_s2, $rose(result.valid), $past(s2_valid_reg))

endmodule

`default_nettype wire
